// ----- rtl/core/cst_pkg.sv -----
// Shared constants and codes of the counting semaphore table.
// No dependencies; imported by the channel interfaces, the core and its checker.
package cst_pkg;

	localparam int NUM_SEMS      = 16;
	localparam int WAIT_DEPTH    = 8;
	localparam int PID_BITS      = 16;

	localparam int ID_BITS       = 4;
	localparam int VALUE_BITS    = 32;
	localparam int REPLY_BITS    = 16;
	localparam int PID_PORT_BITS = 16;

	localparam int SEM_W       = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int SLOT_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int FILL_W      = $clog2(WAIT_DEPTH + 1);
	localparam int STORE_DEPTH = NUM_SEMS * WAIT_DEPTH;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	typedef enum logic [1:0] {
		ACT_OPEN  = 2'd0,
		ACT_WAIT  = 2'd1,
		ACT_POST  = 2'd2,
		ACT_CLOSE = 2'd3
	} cst_action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_OPEN   = 2'd1,
		ST_QUEUE_FULL = 2'd2
	} cst_status_t;

endpackage

// ----- rtl/core/cst_req_if.sv -----
// Request channel of the counting semaphore table: valid/ready plus request fields.
// Depends on cst_pkg for field widths.
interface cst_req_if import cst_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               action;
	logic [ID_BITS-1:0]       sem_id;
	logic [VALUE_BITS-1:0]    init_value;
	logic [PID_PORT_BITS-1:0] caller_pid;

	modport source (output valid, action, sem_id, init_value, caller_pid, input ready);
	modport sink   (input valid, action, sem_id, init_value, caller_pid, output ready);
endinterface

// ----- rtl/core/cst_rsp_if.sv -----
// Response channel of the counting semaphore table: valid/ready plus result fields.
// Depends on cst_pkg for field widths.
interface cst_rsp_if import cst_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [REPLY_BITS-1:0]    reply_value;
	logic                     caller_blocked;
	logic                     wake_valid;
	logic [PID_PORT_BITS-1:0] wake_pid;

	modport source (output valid, status, reply_value, caller_blocked, wake_valid, wake_pid,
		input ready);
	modport sink   (input valid, status, reply_value, caller_blocked, wake_valid, wake_pid,
		output ready);
endinterface

// ----- rtl/core/counting_semaphore_table_core.sv -----
// Counting semaphore table core: per-entry value, open count and FIFO of blocked pids.
// Depends on cst_pkg, cst_req_if and cst_rsp_if.

// Each request gives one response after it is accepted, and a new
// request is taken every cycle as long as responses are taken. The request
// sits in an input register while the entry state (open flag,
// value, open count, queue head and fill) is read, updated and written back;
// the waiter memory is read alongside it, and its registered read data
// forms the result register together with status, reply and flags. A request
// naming an entry that is not open (other than open) returns status 1. Wait on
// a zero value queues the caller pid (status 2 when the queue is full), post
// hands back the oldest queued pid, and the last close discards the queue.
// No clearing pass is needed after reset.
module counting_semaphore_table_core import cst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	cst_req_if.sink req,
	cst_rsp_if.source rsp
);

	localparam int SUM_W = FILL_W + 1;

	// input register
	logic                  valid_s1;
	cst_action_t           action_s1;
	logic [ID_BITS-1:0]    sem_id_s1;
	logic [VALUE_BITS-1:0] init_value_s1;
	logic [PID_BITS-1:0]   pid_s1;

	// result register
	logic                valid_s2;
	cst_status_t         status_s2;
	logic [REPLY_BITS-1:0] reply_s2;
	logic                blocked_s2;
	logic                wake_s2;
	logic [PID_BITS-1:0] rdata_s2;

	// entry state
	logic [NUM_SEMS-1:0]   entry_open_q;
	logic [VALUE_BITS-1:0] sem_count_q  [NUM_SEMS];
	logic [REPLY_BITS-1:0] open_refs_q  [NUM_SEMS];
	logic [SLOT_W-1:0]     queue_head_q [NUM_SEMS];
	logic [FILL_W-1:0]     queue_fill_q [NUM_SEMS];

	logic [PID_BITS-1:0] waiter_store [STORE_DEPTH];

	logic adv;
	logic in_range;
	logic [SEM_W-1:0] idx;
	logic [ID_BITS+SEM_W-1:0] idx_wide;
	logic [PID_PORT_BITS+PID_BITS-1:0] pid_in_wide;
	logic [PID_BITS+PID_PORT_BITS-1:0] pid_out_wide;

	logic                  cur_open;
	logic [VALUE_BITS-1:0] cur_count;
	logic [REPLY_BITS-1:0] cur_refs;
	logic [SLOT_W-1:0]     cur_head;
	logic [FILL_W-1:0]     cur_fill;

	logic                  nxt_open;
	logic [VALUE_BITS-1:0] nxt_count;
	logic [REPLY_BITS-1:0] nxt_refs;
	logic [SLOT_W-1:0]     nxt_head;
	logic [FILL_W-1:0]     nxt_fill;

	cst_status_t           status_c;
	logic [REPLY_BITS-1:0] reply_c;
	logic                  blocked_c;
	logic                  wake_c;
	logic                  mem_we;

	logic [SUM_W-1:0]  tail_sum;
	logic [SLOT_W-1:0] tail_slot;
	logic [SLOT_W-1:0] head_inc;
	logic [ADDR_W-1:0] mem_addr;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1     <= cst_action_t'(req.action);
			sem_id_s1     <= req.sem_id;
			init_value_s1 <= req.init_value;
			pid_s1        <= pid_in_wide[PID_BITS-1:0];
		end
		if (adv) begin
			status_s2  <= status_c;
			reply_s2   <= reply_c;
			blocked_s2 <= blocked_c;
			wake_s2    <= wake_c;
		end
	end

	assign pid_in_wide = {{PID_PORT_BITS{1'b0}}, req.caller_pid};
	assign idx_wide    = {{SEM_W{1'b0}}, sem_id_s1};
	assign idx         = idx_wide[SEM_W-1:0];
	assign in_range    = int'(sem_id_s1) < NUM_SEMS;

	assign cur_open  = entry_open_q[idx];
	assign cur_count = sem_count_q[idx];
	assign cur_refs  = open_refs_q[idx];
	assign cur_head  = queue_head_q[idx];
	assign cur_fill  = queue_fill_q[idx];

	// tail slot wraps around the ring of each entry
	assign tail_sum  = SUM_W'(cur_head) + SUM_W'(cur_fill);
	assign tail_slot = (tail_sum >= SUM_W'(WAIT_DEPTH)) ?
		SLOT_W'(tail_sum - SUM_W'(WAIT_DEPTH)) : SLOT_W'(tail_sum);
	assign head_inc  = (int'(cur_head) == WAIT_DEPTH - 1) ? '0 : SLOT_W'(cur_head + 1'b1);

	assign mem_addr = ADDR_W'(idx) * ADDR_W'(WAIT_DEPTH) +
		ADDR_W'((action_s1 == ACT_POST) ? cur_head : tail_slot);

	always_comb begin
		nxt_open  = cur_open;
		nxt_count = cur_count;
		nxt_refs  = cur_refs;
		nxt_head  = cur_head;
		nxt_fill  = cur_fill;
		status_c  = ST_OK;
		reply_c   = '0;
		blocked_c = 1'b0;
		wake_c    = 1'b0;
		mem_we    = 1'b0;
		if (!in_range) begin
			status_c = ST_NOT_OPEN;
		end else if (action_s1 == ACT_OPEN) begin
			if (cur_open) begin
				if (cur_refs != '1) begin
					nxt_refs = cur_refs + 1'b1;
				end
			end else begin
				nxt_open  = 1'b1;
				nxt_count = init_value_s1;
				nxt_refs  = REPLY_BITS'(1);
				nxt_head  = '0;
				nxt_fill  = '0;
			end
			reply_c = REPLY_BITS'(sem_id_s1);
		end else if (!cur_open) begin
			status_c = ST_NOT_OPEN;
		end else begin
			case (action_s1)
				ACT_WAIT: begin
					if (cur_count != '0) begin
						nxt_count = cur_count - 1'b1;
					end else if (int'(cur_fill) >= WAIT_DEPTH) begin
						status_c = ST_QUEUE_FULL;
					end else begin
						mem_we    = 1'b1;
						nxt_fill  = cur_fill + 1'b1;
						blocked_c = 1'b1;
					end
				end
				ACT_POST: begin
					if (cur_fill == '0) begin
						if (cur_count != '1) begin
							nxt_count = cur_count + 1'b1;
						end
					end else begin
						nxt_head = head_inc;
						nxt_fill = cur_fill - 1'b1;
						wake_c   = 1'b1;
					end
				end
				ACT_CLOSE: begin
					if (cur_refs > REPLY_BITS'(1)) begin
						nxt_refs = cur_refs - 1'b1;
						reply_c  = cur_refs - 1'b1;
					end else begin
						// last reference: free the entry and drop any waiters
						nxt_refs = '0;
						nxt_open = 1'b0;
						nxt_head = '0;
						nxt_fill = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_open_q <= '0;
			for (int i = 0; i < NUM_SEMS; i++) begin
				queue_head_q[i] <= '0;
				queue_fill_q[i] <= '0;
			end
		end else if (adv && in_range) begin
			entry_open_q[idx] <= nxt_open;
			queue_head_q[idx] <= nxt_head;
			queue_fill_q[idx] <= nxt_fill;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_range) begin
			sem_count_q[idx] <= nxt_count;
			open_refs_q[idx] <= nxt_refs;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && mem_we) begin
			waiter_store[mem_addr] <= pid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_s2 <= waiter_store[mem_addr];
		end
	end

	assign pid_out_wide = {{PID_PORT_BITS{1'b0}}, rdata_s2};

	assign rsp.valid          = valid_s2;
	assign rsp.status         = status_s2;
	assign rsp.reply_value    = reply_s2;
	assign rsp.caller_blocked = blocked_s2;
	assign rsp.wake_valid     = wake_s2;
	assign rsp.wake_pid       = wake_s2 ? pid_out_wide[PID_PORT_BITS-1:0] : '0;

endmodule

// ----- rtl/core/cst_checker.sv -----
// Port-level checks of the counting semaphore table core, bound to its top level.
// Depends on cst_pkg and counting_semaphore_table_core.
module cst_checker import cst_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [1:0]               rsp_status,
	input logic [REPLY_BITS-1:0]    rsp_reply_value,
	input logic                     rsp_caller_blocked,
	input logic                     rsp_wake_valid,
	input logic [PID_PORT_BITS-1:0] rsp_wake_pid
);

	// every accepted request is followed by a valid response on the output
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("no response two cycles after an accepted request");

	// with nothing waiting at the output the input must be open
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled while no response is pending");

	// blocking and waking are exclusive and only come with ok status
	a_flags_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_caller_blocked && rsp_wake_valid) &&
			(!(rsp_caller_blocked || rsp_wake_valid) || rsp_status == ST_OK))
		else $error("inconsistent blocked/wake flags");

	a_wake_pid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_wake_valid |-> rsp_wake_pid == '0)
		else $error("wake pid set without a wake");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_reply_value) && $stable(rsp_caller_blocked) &&
			$stable(rsp_wake_valid) && $stable(rsp_wake_pid))
		else $error("stalled response changed");

endmodule

bind counting_semaphore_table_core cst_checker u_cst_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_reply_value    (rsp.reply_value),
	.rsp_caller_blocked (rsp.caller_blocked),
	.rsp_wake_valid     (rsp.wake_valid),
	.rsp_wake_pid       (rsp.wake_pid)
);

// ----- sim/counting_semaphore_table_checker.sv -----
// Response checker for the counting semaphore table: watches both channels,
// predicts each response from its own copy of the table and compares.
// Depends on cst_pkg, cst_req_if and cst_rsp_if.
module counting_semaphore_table_checker import cst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	cst_req_if    req,
	cst_rsp_if    rsp,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		cst_status_t             status;
		logic [REPLY_BITS-1:0]   reply_value;
		logic                    caller_blocked;
		logic                    wake_valid;
		logic [PID_PORT_BITS-1:0] wake_pid;
	} sem_reply_t;

	logic                  sem_live   [NUM_SEMS];
	logic [VALUE_BITS-1:0] sem_value  [NUM_SEMS];
	logic [15:0]           sem_refs   [NUM_SEMS];
	logic [PID_BITS-1:0]   sem_waiter [NUM_SEMS][WAIT_DEPTH];
	logic [SLOT_W-1:0]     sem_head   [NUM_SEMS];
	logic [FILL_W-1:0]     sem_fill   [NUM_SEMS];

	sem_reply_t expected_replies[$];

	function automatic sem_reply_t apply_semaphore_request(cst_action_t act,
		logic [ID_BITS-1:0] id, logic [VALUE_BITS-1:0] initv, logic [PID_BITS-1:0] pid);
		sem_reply_t r;
		logic [SLOT_W-1:0] slot;
		r = '0;
		r.status = ST_OK;
		if (int'(id) >= NUM_SEMS) begin
			r.status = ST_NOT_OPEN;
		end else if (act == ACT_OPEN) begin
			if (sem_live[id]) begin
				if (sem_refs[id] != 16'hFFFF)
					sem_refs[id]++;
			end else begin
				sem_live[id]  = 1'b1;
				sem_value[id] = initv;
				sem_refs[id]  = 16'd1;
				sem_head[id]  = '0;
				sem_fill[id]  = '0;
			end
			r.reply_value = REPLY_BITS'(id);
		end else if (!sem_live[id]) begin
			r.status = ST_NOT_OPEN;
		end else begin
			case (act)
				ACT_WAIT: begin
					if (sem_value[id] != '0) begin
						sem_value[id]--;
					end else if (int'(sem_fill[id]) >= WAIT_DEPTH) begin
						r.status = ST_QUEUE_FULL;
					end else begin
						slot = SLOT_W'((int'(sem_head[id]) + int'(sem_fill[id])) % WAIT_DEPTH);
						sem_waiter[id][slot] = pid;
						sem_fill[id]++;
						r.caller_blocked = 1'b1;
					end
				end
				ACT_POST: begin
					if (sem_fill[id] == '0) begin
						if (sem_value[id] != '1)
							sem_value[id]++;
					end else begin
						r.wake_pid   = PID_PORT_BITS'(sem_waiter[id][sem_head[id]]);
						r.wake_valid = 1'b1;
						sem_head[id] = SLOT_W'((int'(sem_head[id]) + 1) % WAIT_DEPTH);
						sem_fill[id]--;
					end
				end
				default: begin
					// last reference frees the entry and drops its waiters
					if (sem_refs[id] > 16'd1) begin
						sem_refs[id]--;
						r.reply_value = REPLY_BITS'(sem_refs[id]);
					end else begin
						sem_refs[id] = '0;
						sem_live[id] = 1'b0;
						sem_head[id] = '0;
						sem_fill[id] = '0;
					end
				end
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sem_reply_t got;
		sem_reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEMS; i++) begin
				sem_live[i] = 1'b0;
				sem_head[i] = '0;
				sem_fill[i] = '0;
			end
			expected_replies.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// retire the response first: it always belongs to an older request
			if (rsp.valid && rsp.ready) begin
				got.status         = cst_status_t'(rsp.status);
				got.reply_value    = rsp.reply_value;
				got.caller_blocked = rsp.caller_blocked;
				got.wake_valid     = rsp.wake_valid;
				got.wake_pid       = rsp.wake_pid;
				if (expected_replies.size() == 0) begin
					$display("%0t: response with no request outstanding: status=%0d reply=%0h",
						$time, got.status, got.reply_value);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					if (got !== want) begin
						$display({"%0t: response mismatch: expected status=%0d reply=%0h ",
							"blocked=%0b wake=%0b pid=%0h, actual status=%0d reply=%0h ",
							"blocked=%0b wake=%0b pid=%0h"}, $time,
							want.status, want.reply_value, want.caller_blocked,
							want.wake_valid, want.wake_pid,
							got.status, got.reply_value, got.caller_blocked,
							got.wake_valid, got.wake_pid);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_replies.push_back(apply_semaphore_request(cst_action_t'(req.action),
					req.sem_id, req.init_value, req.caller_pid[PID_BITS-1:0]));
			pending = expected_replies.size();
		end
	end

endmodule

// ----- sim/counting_semaphore_table_core_test.sv -----
// Testbench top for counting_semaphore_table_core: drives directed and random
// semaphore requests with bursty input and a stalling receiver, gives the verdict.
// Depends on cst_pkg, both channel interfaces and counting_semaphore_table_checker.
module counting_semaphore_table_core_test import cst_pkg::*; ();

	localparam int RANDOM_REQUESTS = 1360;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   back_to_back;
	bit   hold_off_go;
	int   burst_left;

	cst_req_if req ();
	cst_rsp_if rsp ();

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	counting_semaphore_table_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	counting_semaphore_table_checker semaphore_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	task automatic send_request(input cst_action_t act, input logic [ID_BITS-1:0] id,
		input logic [VALUE_BITS-1:0] initv, input logic [PID_PORT_BITS-1:0] pid);
		req.valid      <= 1'b1;
		req.action     <= act;
		req.sem_id     <= id;
		req.init_value <= initv;
		req.caller_pid <= pid;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if (!back_to_back) begin
			if (burst_left == 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_random_request();
		cst_action_t           act;
		logic [ID_BITS-1:0]    id;
		logic [VALUE_BITS-1:0] initv;
		int                    pick;
		pick = $urandom_range(0, 99);
		act = (pick < 20) ? ACT_OPEN : (pick < 55) ? ACT_WAIT : (pick < 85) ? ACT_POST : ACT_CLOSE;
		// keep most traffic on a few entries so queues fill and drain
		id = ($urandom_range(0, 3) == 0) ? ID_BITS'($urandom_range(0, NUM_SEMS - 1))
			: ID_BITS'(8 + $urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 60)
			initv = '0;
		else if (pick < 80)
			initv = VALUE_BITS'($urandom_range(1, 3));
		else if (pick < 90)
			initv = $urandom;
		else
			initv = '1;
		send_request(act, id, initv, PID_PORT_BITS'($urandom));
	endtask

	// receiver: stretches of steady, random, sparse and mostly-set ready, plus one long hold-off
	initial begin
		int mode;
		int stretch;
		bit held;
		rsp.ready <= 1'b0;
		held = 1'b0;
		forever begin
			mode    = $urandom_range(0, 3);
			stretch = $urandom_range(10, 80);
			for (int i = 0; i < stretch; i++) begin
				if (hold_off_go && !held) begin
					held = 1'b1;
					rsp.ready <= 1'b0;
					repeat (150) @(posedge clk);
				end
				case (mode)
					0:       rsp.ready <= 1'b1;
					1:       rsp.ready <= 1'($urandom_range(0, 1));
					2:       rsp.ready <= ($urandom_range(0, 3) == 0);
					default: rsp.ready <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [PID_PORT_BITS-1:0] waiter_pids [9];
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.action     <= ACT_OPEN;
		req.sem_id     <= '0;
		req.init_value <= '0;
		req.caller_pid <= '0;
		back_to_back = 1'b0;
		hold_off_go  = 1'b0;
		burst_left   = 4;
		waiter_pids  = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h0001,
			16'h8000, 16'h1234, 16'hFEDC, 16'h7777};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// requests on entries that are not open
		send_request(ACT_WAIT, 4'd5, '0, 16'h0042);
		send_request(ACT_POST, 4'd5, '0, 16'h0000);
		send_request(ACT_CLOSE, 4'd5, '0, 16'h0000);
		// fill the wait queue, overflow it, then drain it in order
		send_request(ACT_OPEN, 4'd0, '0, 16'h0000);
		foreach (waiter_pids[i])
			send_request(ACT_WAIT, 4'd0, '0, waiter_pids[i]);
		repeat (9)
			send_request(ACT_POST, 4'd0, '0, 16'h0000);
		send_request(ACT_WAIT, 4'd0, '0, 16'h0003);
		// value saturation and reference counting
		send_request(ACT_OPEN, 4'd15, '1, 16'hFFFF);
		send_request(ACT_POST, 4'd15, '0, 16'h0000);
		send_request(ACT_WAIT, 4'd15, '0, 16'h0000);
		send_request(ACT_OPEN, 4'd15, 32'h0000_0007, 16'h0000);
		send_request(ACT_CLOSE, 4'd15, '0, 16'h0000);
		send_request(ACT_CLOSE, 4'd15, '0, 16'h0000);
		send_request(ACT_WAIT, 4'd15, '0, 16'h0000);
		// last close drops pending waiters
		send_request(ACT_OPEN, 4'd3, '0, 16'h0000);
		send_request(ACT_WAIT, 4'd3, '0, 16'hBEEF);
		send_request(ACT_WAIT, 4'd3, '0, 16'hCAFE);
		send_request(ACT_CLOSE, 4'd3, '0, 16'h0000);
		send_request(ACT_OPEN, 4'd3, '0, 16'h0000);
		send_request(ACT_POST, 4'd3, '0, 16'h0000);

		// stack several opens on one entry, then release them back to back
		back_to_back = 1'b1;
		repeat (3)
			send_request(ACT_OPEN, 4'd1, 32'h8000_0000, 16'h0000);
		repeat (3)
			send_request(ACT_CLOSE, 4'd1, '0, 16'h0000);
		back_to_back = 1'b0;

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS / 2) begin
				// hold the receiver off while requests keep coming
				back_to_back = 1'b1;
				hold_off_go  = 1'b1;
				repeat (40)
					send_random_request();
				back_to_back = 1'b0;
			end
			send_random_request();
		end

		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- counting_semaphore_table_core.f -----
rtl/core/cst_pkg.sv
rtl/core/cst_req_if.sv
rtl/core/cst_rsp_if.sv
rtl/core/counting_semaphore_table_core.sv
rtl/core/cst_checker.sv
sim/counting_semaphore_table_checker.sv
sim/counting_semaphore_table_core_test.sv
